// ----- design/adamax_pkg.sv -----
`default_nettype none
package adamax_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CFG_W  = 24;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned CFG_IDX_W = 2;

  // Store depth spans the whole index range; Q8.24 arithmetic throughout.
  localparam int unsigned WEIGHT_DEPTH = 1024;
  localparam int unsigned FRAC_BITS    = 24;

  localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_DECAY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_DECAY  = 2'd2;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PMUL,
    ST_RDIV,
    ST_READ,
    ST_MOM,
    ST_QDIV,
    ST_STEP,
    ST_WB
  } state_t;

  // Handshake between the sequencer and the shared divider.
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// ----- design/adamax_div.sv -----
`default_nettype none
module adamax_div (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire adamax_pkg::div_req_t req,
  output adamax_pkg::div_rsp_t      rsp
);
  import adamax_pkg::*;

  // Restoring divider, one quotient bit per cycle.
  logic [63:0] quo_r, quo_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] dsr_r, dsr_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [33:0] trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = '0;
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
      cnt_nxt  = 7'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      trial = {rem_r, quo_r[63]} - {2'b00, dsr_r};
      if (!trial[33]) begin
        rem_nxt = trial[32:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[31:0], quo_r[63]};
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule
`default_nettype wire

// ----- design/adamax_weight_update_core.sv -----
`default_nettype none
// Adamax weight update engine, signed fixed point (Q8.24).
// Input: raise start with in_command, in_weight_index, in_operand_value and
// in_pass_start; the item transfers at the first rising edge with busy low.
// A load (command 0) writes the weight and clears both moments; an update
// (command 1) applies a gradient, with in_pass_start first advancing the
// timestep, the beta1 power and the corrected rate.
// Output: out_valid is high for exactly one cycle with out_index,
// out_new_weight and out_saturated. The receiver cannot stall; every result
// transfers in the cycle it is shown.
// An update takes longer than a load; it skips the moment division when the
// second moment is zero, and the pass flag adds the rate division while the
// bias correction applies. The 64-step radix-2 divider is shared by m/v and
// the rate correction.
// One item is in flight at a time: busy drops in the cycle the result shows,
// so the next item can transfer at the edge ending it.
// Reset loads the register defaults, clears the timestep and sets b1^t to
// one. The weight and moment memories are not cleared: load an entry before
// updating it.
// Configuration: cfg_wr_en, cfg_index, cfg_data; write only while idle.
module adamax_weight_update_core #(
  parameter int unsigned CORRECTION_STEPS = 100
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                in_command,
  input  wire logic [adamax_pkg::IDX_W-1:0]        in_weight_index,
  input  wire logic signed [adamax_pkg::DATA_W-1:0] in_operand_value,
  input  wire logic                                in_pass_start,
  output logic                                     out_valid,
  output logic [adamax_pkg::IDX_W-1:0]             out_index,
  output logic signed [adamax_pkg::DATA_W-1:0]     out_new_weight,
  output logic                                     out_saturated,
  input  wire logic                                cfg_wr_en,
  input  wire logic [adamax_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [adamax_pkg::CFG_W-1:0]        cfg_data
);
  import adamax_pkg::*;

  localparam int unsigned AW = $clog2(WEIGHT_DEPTH);
  localparam logic [63:0] ONE_FX = 64'd1 << FRAC_BITS;
  localparam logic [6:0] CORR_LIM = 7'(CORRECTION_STEPS);

  // configuration registers
  logic [CFG_W-1:0] lr_r, b1_r, b2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r <= 24'd33554;
      b1_r <= 24'd15099494;
      b2_r <= 24'd16760439;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_LEARNING_RATE: lr_r <= cfg_data;
        REG_FIRST_DECAY:   b1_r <= cfg_data;
        REG_SECOND_DECAY:  b2_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // state memories: weights, and both moments side by side in one word
  logic [DATA_W-1:0]   w_mem   [WEIGHT_DEPTH];
  logic [2*DATA_W-1:0] mom_mem [WEIGHT_DEPTH];
  logic [DATA_W-1:0]   w_rd_r;
  logic [2*DATA_W-1:0] mom_rd_r;
  logic [DATA_W-1:0]   m_rd, v_rd;
  logic                mem_we;
  logic [DATA_W-1:0]   w_wd, m_wd, v_wd;

  assign m_rd = mom_rd_r[2*DATA_W-1:DATA_W];
  assign v_rd = mom_rd_r[DATA_W-1:0];

  // item registers
  state_t state_r, state_nxt;
  logic               cmd_r;
  logic [IDX_W-1:0]   idx_r;
  logic [AW-1:0]      addr_r;
  logic signed [31:0] g_r;
  logic               pass_r;
  logic [6:0]         tstep_r, tstep_nxt;
  logic [24:0]        pow_r, pow_nxt;
  logic [31:0]        crate_r, crate_nxt;
  logic signed [31:0] m_r, m_nxt;
  logic [31:0]        v_r, v_nxt;
  logic [39:0]        step_r, step_nxt;
  logic [63:0]        prod_r, prod_nxt;
  logic signed [31:0] nw_r, nw_nxt;
  logic               sat_r, sat_nxt;
  logic               rdiv_wait_r, rdiv_wait_nxt;
  logic               skip;

  div_req_t dreq;
  div_rsp_t drsp;

  adamax_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .rsp  (drsp)
  );

  logic accept;
  assign accept = start && !busy;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) begin
        state_nxt = (in_command == CMD_UPDATE && in_pass_start) ? ST_PMUL : ST_READ;
      end
      ST_PMUL: state_nxt = ST_RDIV;
      ST_RDIV: if (drsp.done || skip) state_nxt = ST_READ;
      ST_READ: state_nxt = (cmd_r == CMD_LOAD) ? ST_WB : ST_MOM;
      ST_MOM:  state_nxt = ST_QDIV;
      ST_QDIV: if (drsp.done || skip) state_nxt = ST_STEP;
      ST_STEP: state_nxt = ST_WB;
      ST_WB:   state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath
  logic [49:0]        pp;
  logic signed [63:0] macc;
  logic [55:0]        vprod;
  logic signed [63:0] mfl;
  logic [31:0]        vfl, ag;
  logic [31:0]        am;
  logic [63:0]        qv, qlim;
  logic [64:0]        den;
  logic signed [40:0] wsum;
  logic [95:0]        sprod;

  always_comb begin
    tstep_nxt = tstep_r;
    pow_nxt   = pow_r;
    crate_nxt = crate_r;
    m_nxt     = m_r;
    v_nxt     = v_r;
    step_nxt  = step_r;
    prod_nxt  = prod_r;
    nw_nxt    = nw_r;
    sat_nxt   = sat_r;
    dreq      = '0;
    mem_we    = 1'b0;
    w_wd      = nw_r;
    m_wd      = m_r;
    v_wd      = v_r;
    pp = '0; macc = '0; vprod = '0; mfl = '0; vfl = '0; ag = '0; am = '0;
    qv = '0; qlim = '0; den = '0; wsum = '0; sprod = '0;
    unique case (state_r)
      ST_PMUL: begin
        // advance t and b1^t
        if (tstep_r != 7'd127) tstep_nxt = tstep_r + 7'd1;
        pp = 50'(pow_r) * 50'(b1_r);
        pp = pp >> FRAC_BITS;
        pow_nxt = (|pp[49:25]) ? 25'h1FFFFFF : pp[24:0];
      end
      ST_RDIV: begin
        den = 65'(ONE_FX) - 65'(pow_r);
        if (rdiv_wait_r) begin
          if (drsp.done) begin
            crate_nxt = (|drsp.quotient[63:32]) ? 32'hFFFFFFFF : drsp.quotient[31:0];
          end
        end else if (tstep_r >= CORR_LIM || den[64] || den == '0) begin
          crate_nxt = 32'(lr_r);
        end else begin
          dreq.start    = 1'b1;
          dreq.dividend = 64'(lr_r) << FRAC_BITS;
          dreq.divisor  = den[31:0];
        end
      end
      ST_MOM: begin
        macc = $signed({{40{b1_r[23] & 1'b0}}, b1_r}) * $signed(m_rd)
             + $signed(64'(ONE_FX) - 64'(b1_r)) * 64'(g_r);
        mfl  = macc >>> FRAC_BITS;
        if (mfl > 64'sd2147483647) m_nxt = 32'sh7FFFFFFF;
        else if (mfl < -64'sd2147483648) m_nxt = 32'sh80000000;
        else m_nxt = mfl[31:0];
        vprod = 56'(b2_r) * 56'($unsigned(v_rd[30:0]));
        vfl   = 32'(vprod >> FRAC_BITS);
        ag    = g_r[31] ? 32'(-{g_r[31], g_r}) : g_r;
        if (g_r == 32'sh80000000) ag = 32'h7FFFFFFF;
        v_nxt = (ag > vfl) ? ag : vfl;
        if (v_nxt[31]) v_nxt = 32'h7FFFFFFF;
        prod_nxt = '0;
      end
      ST_QDIV: begin
        am = m_r[31] ? 32'(-m_r) : m_r;
        if (!rdiv_wait_r) begin
          if (v_r != '0) begin
            dreq.start    = 1'b1;
            dreq.dividend = 64'(am) << FRAC_BITS;
            dreq.divisor  = v_r;
          end
        end else if (drsp.done) begin
          qv   = drsp.quotient;
          qlim = m_r[31] ? 64'h80000000 : 64'h7FFFFFFF;
          if (qv > qlim) qv = qlim;
          prod_nxt = qv;
        end
      end
      ST_STEP: begin
        // step can reach 2^39 with a large corrected rate; clip on the sum
        sprod    = 96'(crate_r) * 96'(prod_r[31:0]);
        step_nxt = 40'(sprod >> FRAC_BITS);
        wsum = m_r[31] ? 41'($signed(w_rd_r)) - $signed({1'b0, step_nxt})
                       : 41'($signed(w_rd_r)) + $signed({1'b0, step_nxt});
        sat_nxt = (wsum > 41'sd2147483647) || (wsum < -41'sd2147483648);
        nw_nxt  = sat_nxt ? (wsum[40] ? 32'sh80000000 : 32'sh7FFFFFFF) : wsum[31:0];
      end
      ST_WB: begin
        mem_we = 1'b1;
        if (cmd_r == CMD_LOAD) begin
          w_wd = g_r; m_wd = '0; v_wd = '0;
          nw_nxt = g_r; sat_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // divider wait flag: set after issuing, cleared on completion
  always_comb begin
    rdiv_wait_nxt = rdiv_wait_r;
    if (dreq.start) rdiv_wait_nxt = 1'b1;
    else if (drsp.done) rdiv_wait_nxt = 1'b0;
  end
  // skip flag: divider not needed in this state
  assign skip = (state_r == ST_RDIV && !rdiv_wait_r && !dreq.start)
             || (state_r == ST_QDIV && !rdiv_wait_r && !dreq.start);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tstep_r     <= '0;
      pow_r       <= 25'(ONE_FX);
      crate_r     <= '0;
      rdiv_wait_r <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tstep_r     <= tstep_nxt;
      pow_r       <= pow_nxt;
      crate_r     <= crate_nxt;
      rdiv_wait_r <= rdiv_wait_nxt;
      out_valid   <= (state_r == ST_WB);
    end
    prod_r <= prod_nxt;
    m_r    <= m_nxt;
    v_r    <= v_nxt;
    step_r <= step_nxt;
    nw_r   <= nw_nxt;
    sat_r  <= sat_nxt;
    if (accept) begin
      cmd_r  <= in_command;
      idx_r  <= in_weight_index;
      // the store covers the whole index range, so the index is the address
      addr_r <= in_weight_index[AW-1:0];
      g_r    <= in_operand_value;
      pass_r <= in_pass_start;
    end
    if (state_r == ST_WB) begin
      out_index      <= idx_r;
      out_new_weight <= (cmd_r == CMD_LOAD) ? g_r : nw_r;
      out_saturated  <= (cmd_r == CMD_LOAD) ? 1'b0 : sat_r;
    end
  end

  // memories: read during ST_READ, write back in ST_WB
  always_ff @(posedge clk) begin
    if (state_r == ST_READ) begin
      w_rd_r   <= w_mem[addr_r];
      mom_rd_r <= mom_mem[addr_r];
    end
    if (mem_we) begin
      w_mem[addr_r]   <= w_wd;
      mom_mem[addr_r] <= {m_wd, v_wd};
    end
  end

  assign busy = (state_r != ST_IDLE);

`ifndef SYNTHESIS
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held");
  a_busy_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy) else $error("busy not raised after transfer");
  a_load_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && cmd_r == CMD_LOAD) |-> !out_saturated) else $error("load flagged saturated");
  a_pass_only_update: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PMUL) |-> (cmd_r == CMD_UPDATE && pass_r)) else $error("pass on load");
`endif

endmodule
`default_nettype wire

// ----- verif/adamax_checker.sv -----
`timescale 1ns / 100ps
module adamax_checker (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     start,
  input  logic                                     busy,
  input  logic                                     in_command,
  input  logic [adamax_pkg::IDX_W-1:0]             in_weight_index,
  input  logic signed [adamax_pkg::DATA_W-1:0]     in_operand_value,
  input  logic                                     in_pass_start,
  input  logic                                     out_valid,
  input  logic [adamax_pkg::IDX_W-1:0]             out_index,
  input  logic signed [adamax_pkg::DATA_W-1:0]     out_new_weight,
  input  logic                                     out_saturated,
  input  logic                                     cfg_wr_en,
  input  logic [adamax_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [adamax_pkg::CFG_W-1:0]             cfg_data,
  output int                                       errors,
  output int                                       pending,
  output int                                       clipped
);
  import adamax_pkg::*;

  localparam int DEPTH = 1024;
  localparam int FRAC = 24;
  localparam longint ONE = 64'sd1 << FRAC;
  localparam longint S32MAX = 64'sd2147483647;
  localparam longint S32MIN = -64'sd2147483648;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] weight;
    logic              sat;
  } weight_write_t;

  weight_write_t written_q[$];

  bit [CFG_W-1:0] rate, beta1, beta2;
  int             weights [DEPTH];
  int             first_mom [DEPTH];
  int             second_mom [DEPTH];
  bit [6:0]       step_t;
  bit [24:0]      beta1_pow;
  bit [31:0]      rate_corr;

  function automatic longint clip32(longint x);
    if (x > S32MAX) return S32MAX;
    if (x < S32MIN) return S32MIN;
    return x;
  endfunction

  function automatic void advance_timestep();
    bit [63:0] p;
    bit [63:0] cr;
    longint    den;
    if (step_t < 7'd127) step_t++;
    p = (64'(beta1_pow) * 64'(beta1)) >> FRAC;
    if (p > 64'h1FF_FFFF) p = 64'h1FF_FFFF;
    beta1_pow = p[24:0];
    if (step_t < 7'd100) begin
      den = ONE - longint'(beta1_pow);
      if (den <= 0) begin
        rate_corr = 32'(rate);
      end else begin
        cr = (64'(rate) << FRAC) / 64'(den);
        rate_corr = (cr > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : cr[31:0];
      end
    end else begin
      rate_corr = 32'(rate);
    end
  endfunction

  // Compute the weight written by one item and advance the local state.
  function automatic weight_write_t weight_after(logic cmd, logic [IDX_W-1:0] idx,
                                                 logic signed [31:0] opv, logic pass);
    weight_write_t r;
    longint        g, m, v, ag, nw;
    bit [63:0]     am, q, qlim, stepv;
    int            i;
    i = int'(idx) % DEPTH;
    r.sat = 1'b0;
    if (cmd == CMD_LOAD) begin
      weights[i] = opv;
      first_mom[i] = 0;
      second_mom[i] = 0;
    end else begin
      if (pass) advance_timestep();
      g = longint'(opv);
      m = (longint'(beta1) * longint'(first_mom[i]) + (ONE - longint'(beta1)) * g) >>> FRAC;
      m = clip32(m);
      v = (longint'(beta2) * longint'(second_mom[i])) >>> FRAC;
      ag = (g < 0) ? -g : g;
      if (ag > v) v = ag;
      if (v > S32MAX) v = S32MAX;
      first_mom[i] = int'(m);
      second_mom[i] = int'(v);
      stepv = 0;
      if (v > 0) begin
        am = (m < 0) ? 64'(-m) : 64'(m);
        q = (am << FRAC) / 64'(v);
        qlim = (m < 0) ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (q > qlim) q = qlim;
        stepv = (64'(rate_corr) * q) >> FRAC;
      end
      nw = longint'(weights[i]) + ((m < 0) ? -longint'(stepv) : longint'(stepv));
      if (nw > S32MAX || nw < S32MIN) r.sat = 1'b1;
      weights[i] = int'(clip32(nw));
    end
    r.idx = idx;
    r.weight = weights[i];
    return r;
  endfunction

  always @(posedge clk) begin
    weight_write_t exp_w;
    if (!rst_n) begin
      rate = 24'd33554;
      beta1 = 24'd15099494;
      beta2 = 24'd16760439;
      step_t = '0;
      beta1_pow = 25'h100_0000;
      rate_corr = '0;
      written_q.delete();
      errors <= 0;
      pending <= 0;
      clipped <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_LEARNING_RATE: rate = cfg_data;
          REG_FIRST_DECAY:   beta1 = cfg_data;
          REG_SECOND_DECAY:  beta2 = cfg_data;
          default: ;
        endcase
      end
      if (out_valid) begin
        if (written_q.size() == 0) begin
          $display("%0t: unexpected result idx %0d weight %h", $time, out_index,
                   out_new_weight);
          errors <= errors + 1;
        end else begin
          exp_w = written_q.pop_front();
          if (out_index !== exp_w.idx || out_new_weight !== exp_w.weight ||
              out_saturated !== exp_w.sat) begin
            $display("%0t: mismatch expected idx %0d weight %h sat %b, actual idx %0d weight %h sat %b",
                     $time, exp_w.idx, exp_w.weight, exp_w.sat, out_index,
                     out_new_weight, out_saturated);
            errors <= errors + 1;
          end
          if (exp_w.sat) clipped <= clipped + 1;
        end
      end
      if (start && !busy)
        written_q.push_back(weight_after(in_command, in_weight_index, in_operand_value,
                                         in_pass_start));
      pending <= written_q.size();
    end
  end

  final_check: assert property (@(posedge clk) 1);
endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
module tb;
  import adamax_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_command = CMD_LOAD;
  logic [IDX_W-1:0] in_weight_index = '0;
  logic signed [DATA_W-1:0] in_operand_value = '0;
  logic in_pass_start = 1'b0;
  logic out_valid;
  logic [IDX_W-1:0] out_index;
  logic signed [DATA_W-1:0] out_new_weight;
  logic out_saturated;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_LEARNING_RATE;
  logic [CFG_W-1:0] cfg_data = '0;

  int errors, pending, clipped;
  int n_loads, n_updates, n_passes, stall_cycles;
  bit loaded [1024];
  bit no_gaps;
  int pool_base;

  always #4 clk = ~clk;

  adamax_weight_update_core dut (
    .clk, .rst_n, .start, .busy, .in_command, .in_weight_index, .in_operand_value,
    .in_pass_start, .out_valid, .out_index, .out_new_weight, .out_saturated,
    .cfg_wr_en, .cfg_index, .cfg_data
  );

  adamax_checker u_checker (
    .clk, .rst_n, .start, .busy, .in_command, .in_weight_index, .in_operand_value,
    .in_pass_start, .out_valid, .out_index, .out_new_weight, .out_saturated,
    .cfg_wr_en, .cfg_index, .cfg_data, .errors, .pending, .clipped
  );

  // Watchdog: end the run if nothing transfers on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= 5000) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Present one item after a random gap and hold it until it transfers.
  // Leave start high on return so a back-to-back item needs no toggle.
  task automatic send_item(logic cmd, int idx, logic [31:0] opv, logic pass);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_weight_index <= idx[IDX_W-1:0];
    in_operand_value <= opv;
    in_pass_start <= pass;
    do @(posedge clk); while (busy);
    if (cmd == CMD_LOAD) begin
      loaded[idx] = 1'b1;
      n_loads++;
    end else begin
      n_updates++;
      if (pass) n_passes++;
    end
  endtask

  // Hold off the sender until every outstanding result has come back.
  task automatic drain();
    start <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] ridx, logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= ridx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_gradient();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 32'($urandom_range(0, 2 ** 21)) - 32'(2 ** 20);
      4, 5:       return $urandom();
      6:          return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      7:          return 32'd0;
      default:    return 32'($urandom_range(0, 2 ** 27)) - 32'(2 ** 26);
    endcase
  endfunction

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(0, 5))
      0:       return 32'h7FFF_FF00 + $urandom_range(0, 255);
      1:       return 32'h8000_0000 + $urandom_range(0, 255);
      2:       return $urandom();
      default: return 32'($urandom_range(0, 2 ** 26)) - 32'(2 ** 25);
    endcase
  endfunction

  // Mostly hammer a small group of entries so moments build up, else roam.
  task automatic random_item();
    int idx;
    idx = ($urandom_range(0, 9) < 7) ? (pool_base + $urandom_range(0, 15)) % 1024
                                     : $urandom_range(0, 1023);
    if (!loaded[idx] || $urandom_range(0, 9) == 0)
      send_item(CMD_LOAD, idx, pick_weight(), 1'($urandom_range(0, 1)));
    else
      send_item(CMD_UPDATE, idx, pick_gradient(), $urandom_range(0, 7) == 0);
  endtask

  task automatic random_phase(int count);
    for (int k = 0; k < count; k++) begin
      if (k % 60 == 0) begin
        no_gaps = ($urandom_range(0, 3) == 0);
        pool_base = $urandom_range(0, 1023);
      end
      random_item();
    end
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, update before any pass, zero second moment, clipping.
    send_item(CMD_LOAD, 0, 32'h7FFF_FFFF, 1'b1);
    send_item(CMD_LOAD, 1023, 32'h8000_0000, 1'b0);
    send_item(CMD_LOAD, 512, 32'h0000_0000, 1'b0);
    send_item(CMD_UPDATE, 512, 32'h0100_0000, 1'b0);
    send_item(CMD_UPDATE, 512, 32'h0000_0000, 1'b0);
    send_item(CMD_LOAD, 341, 32'h0155_5555, 1'b0);
    send_item(CMD_UPDATE, 341, 32'h0000_0000, 1'b1);
    send_item(CMD_UPDATE, 0, 32'h7FFF_FFFF, 1'b1);
    send_item(CMD_UPDATE, 1023, 32'h8000_0000, 1'b0);
    send_item(CMD_UPDATE, 1023, 32'h8000_0000, 1'b1);
    send_item(CMD_UPDATE, 0, 32'h0000_0001, 1'b0);
    send_item(CMD_UPDATE, 512, 32'hFFFF_FFFF, 1'b0);
    drain();

    // Extreme settings: full rate, no decay, then near-one decays.
    write_reg(REG_LEARNING_RATE, 24'hFF_FFFF);
    write_reg(REG_FIRST_DECAY, 24'h00_0000);
    write_reg(REG_SECOND_DECAY, 24'h00_0000);
    send_item(CMD_LOAD, 682, 32'h7FFF_0000, 1'b0);
    send_item(CMD_UPDATE, 682, 32'h0100_0000, 1'b1);
    send_item(CMD_LOAD, 170, 32'h8001_0000, 1'b0);
    send_item(CMD_UPDATE, 170, 32'hFF00_0000, 1'b1);
    drain();
    write_reg(REG_FIRST_DECAY, 24'hFF_FFFF);
    write_reg(REG_SECOND_DECAY, 24'hFF_FFFF);
    send_item(CMD_UPDATE, 0, 32'h8000_0000, 1'b1);
    send_item(CMD_UPDATE, 1023, 32'h7FFF_FFFF, 1'b1);
    drain();

    // Random phases under several register settings, defaults among them.
    write_reg(REG_LEARNING_RATE, 24'd33554);
    write_reg(REG_FIRST_DECAY, 24'd15099494);
    write_reg(REG_SECOND_DECAY, 24'd16760439);
    random_phase(700);
    write_reg(REG_LEARNING_RATE, 24'($urandom()));
    write_reg(REG_FIRST_DECAY, 24'($urandom()));
    write_reg(REG_SECOND_DECAY, 24'($urandom()));
    random_phase(400);
    write_reg(REG_LEARNING_RATE, 24'h00_0000);
    write_reg(REG_FIRST_DECAY, 24'hF0_0000);
    write_reg(REG_SECOND_DECAY, 24'hFF_FFFF);
    random_phase(300);
    write_reg(REG_LEARNING_RATE, 24'hFF_FFFF);
    write_reg(REG_FIRST_DECAY, 24'h00_0001);
    write_reg(REG_SECOND_DECAY, 24'($urandom()));
    random_phase(480);

    repeat (20) @(posedge clk);
    $display("Covered %0d loads and %0d updates, %0d with a pass start.",
             n_loads, n_updates, n_passes);
    $display("Clipped weight writes seen: %0d; mismatches: %0d.", clipped, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
